@@ hw/rtl/lruwe_pkg.sv @@
`default_nettype none

package lruwe_pkg;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [3:0] MAX_RES         = 4'd8;
  localparam logic       REG_MAX_ENTRIES = 1'b0;
  localparam int unsigned PADDR_W        = 3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic        no_compile;
    logic        artifact_present;
    logic        copy_ok;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [63:0] evicted_key;
    logic [5:0]  entry_count;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_END,
    ST_APPLY,
    ST_CHECK,
    ST_EMIT,
    ST_EV_SCAN,
    ST_EV_END,
    ST_EV_TAKE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic scan_start;
    logic ev_start;
    logic rd;
    logic apply;
    logic emit_plain;
    logic ev_take;
  } ctl_t;

  typedef struct packed {
    logic [1:0] func;
    logic       no_compile;
    logic       idx_last;
    logic       need_evict;
    logic       more;
  } stat_t;

  // floor(m*4/5) as a multiply by 205/1024, exact for m*4 below 1024
  function automatic logic [4:0] watermark(logic [4:0] m);
    logic [14:0] p;
    p = 15'({m, 2'b00}) * 15'd205;
    return p[14:10];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lruwe_ram.sv @@
`default_nettype none

module lruwe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/lruwe_ctrl.sv @@
`default_nettype none

module lruwe_ctrl
  import lruwe_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t st_i,
  output ctl_t       ctl_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st_i.func == FUNC_CLEAR) begin
          ctl_o.clear_all = 1'b1;
          state_d         = ST_EMIT;
        end else if ((st_i.func == FUNC_LOOKUP || st_i.func == FUNC_INSERT) &&
                     !st_i.no_compile) begin
          ctl_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        ctl_o.rd = 1'b1;
        if (st_i.idx_last) begin
          state_d = ST_SCAN_END;
        end
      end
      // last read is compared here
      ST_SCAN_END: state_d = ST_APPLY;
      ST_APPLY: begin
        ctl_o.apply = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (st_i.need_evict) begin
          ctl_o.ev_start = 1'b1;
          state_d        = ST_EV_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctl_o.emit_plain = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_EV_SCAN: begin
        ctl_o.rd = 1'b1;
        if (st_i.idx_last) begin
          state_d = ST_EV_END;
        end
      end
      ST_EV_END: state_d = ST_EV_TAKE;
      ST_EV_TAKE: begin
        ctl_o.ev_take = 1'b1;
        if (st_i.more) begin
          ctl_o.ev_start = 1'b1;
          state_d        = ST_EV_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/lruwe_dp.sv @@
`default_nettype none

module lruwe_dp
  import lruwe_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire req_t       req_i,
  input  wire logic [4:0] max_entries_i,
  input  wire ctl_t       ctl_i,
  output stat_t           st_o,
  output logic            res_valid_o,
  output res_t            res_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  req_t             req_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]    count_q, count_d, cnt_dec;
  logic [IW-1:0]    idx_q, idx_d;
  logic             chk_vld_q;
  logic [IW-1:0]    chk_idx_q;
  logic             ev_mode_q, ev_mode_d;
  logic             match_q, match_d, free_q, free_d, found_q, found_d;
  logic [IW-1:0]    match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [31:0]      best_time_q, best_time_d;
  logic [63:0]      best_key_q, best_key_d;
  logic             hit_q, hit_d, added_q, added_d;
  logic [3:0]       n_q, n_d;
  logic             res_valid_q;
  res_t             res_q, res_d;

  logic             key_we, time_we;
  logic [IW-1:0]    time_waddr;
  logic [63:0]      key_rd;
  logic [31:0]      time_rd;
  logic [4:0]       target;
  logic             more;
  logic [5:0]       cnt_sat, cnt_dec_sat;

  lruwe_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (req_q.key),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  lruwe_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (time_waddr),
    .wdata_i (req_q.now),
    .raddr_i (idx_q),
    .rdata_o (time_rd)
  );

  assign target  = watermark(max_entries_i);
  assign cnt_dec = count_q - CW'(1);
  assign more    = (CMPW'(cnt_dec) > CMPW'(target)) && ((n_q + 4'd1) < MAX_RES);
  assign cnt_sat     = (CMPW'(count_q) > CMPW'(63)) ? 6'd63 : 6'(count_q);
  assign cnt_dec_sat = (CMPW'(cnt_dec) > CMPW'(63)) ? 6'd63 : 6'(cnt_dec);

  // store updates
  always_comb begin
    valid_d    = valid_q;
    count_d    = count_q;
    hit_d      = hit_q;
    added_d    = added_q;
    key_we     = 1'b0;
    time_we    = 1'b0;
    time_waddr = match_idx_q;
    if (ctl_i.load) begin
      hit_d   = 1'b0;
      added_d = 1'b0;
    end
    if (ctl_i.clear_all) begin
      valid_d = '0;
      count_d = '0;
    end
    if (ctl_i.apply) begin
      priority if (req_q.func == FUNC_LOOKUP) begin
        if (match_q) begin
          if (!req_q.artifact_present) begin
            valid_d[match_idx_q] = 1'b0;
            count_d              = cnt_dec;
          end else if (req_q.copy_ok) begin
            time_we = 1'b1;
            hit_d   = 1'b1;
          end
        end
      end else if (req_q.func == FUNC_INSERT) begin
        if (match_q) begin
          time_we = 1'b1;
        end else if (req_q.copy_ok && free_q) begin
          key_we              = 1'b1;
          time_we             = 1'b1;
          time_waddr          = free_idx_q;
          valid_d[free_idx_q] = 1'b1;
          count_d             = count_q + CW'(1);
          added_d             = 1'b1;
        end
      end
    end
    if (ctl_i.ev_take) begin
      valid_d[best_idx_q] = 1'b0;
      count_d             = cnt_dec;
    end
  end

  // slot walk: key match and free slot, or oldest entry
  always_comb begin
    idx_d       = idx_q;
    ev_mode_d   = ev_mode_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    best_key_d  = best_key_q;
    if (ctl_i.scan_start || ctl_i.ev_start) begin
      idx_d     = '0;
      ev_mode_d = ctl_i.ev_start;
      match_d   = 1'b0;
      free_d    = 1'b0;
      found_d   = 1'b0;
    end
    if (ctl_i.rd) begin
      idx_d = idx_q + IW'(1);
    end
    if (chk_vld_q) begin
      if (!ev_mode_q) begin
        if (valid_q[chk_idx_q] && key_rd == req_q.key && !match_q) begin
          match_d     = 1'b1;
          match_idx_d = chk_idx_q;
        end
        if (!valid_q[chk_idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = chk_idx_q;
        end
      end else if (valid_q[chk_idx_q] && (!found_q || time_rd < best_time_q)) begin
        // strict compare keeps the lowest slot on equal times
        found_d     = 1'b1;
        best_idx_d  = chk_idx_q;
        best_time_d = time_rd;
        best_key_d  = key_rd;
      end
    end
  end

  always_comb begin
    n_d = n_q;
    if (ctl_i.load) begin
      n_d = '0;
    end else if (ctl_i.ev_take) begin
      n_d = n_q + 4'd1;
    end
  end

  always_comb begin
    res_d = res_q;
    if (ctl_i.emit_plain) begin
      res_d.hit           = hit_q;
      res_d.evicted_valid = 1'b0;
      res_d.evicted_key   = '0;
      res_d.entry_count   = cnt_sat;
      res_d.last          = 1'b1;
    end else if (ctl_i.ev_take) begin
      res_d.hit           = 1'b0;
      res_d.evicted_valid = 1'b1;
      res_d.evicted_key   = best_key_q;
      res_d.entry_count   = cnt_dec_sat;
      res_d.last          = !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      ev_mode_q   <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      added_q     <= 1'b0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      chk_vld_q   <= ctl_i.rd;
      chk_idx_q   <= idx_q;
      ev_mode_q   <= ev_mode_d;
      match_q     <= match_d;
      free_q      <= free_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      added_q     <= added_d;
      n_q         <= n_d;
      res_valid_q <= ctl_i.emit_plain || ctl_i.ev_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    best_key_q  <= best_key_d;
    res_q       <= res_d;
  end

  assign st_o.func       = req_q.func;
  assign st_o.no_compile = req_q.no_compile;
  assign st_o.idx_last   = (idx_q == IW'(SLOTS - 1));
  assign st_o.need_evict = added_q && (CMPW'(count_q) > CMPW'(max_entries_i));
  assign st_o.more       = more;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/lru_index_watermark_evict_unit.sv @@
// Lookup and insert: one pass over the slots through the key RAM read port. An insert
// that evicts gives one result per eviction, each after a new pass over the slots, at
// most 8 evictions per item. Clear, no_compile and unused codes skip the slot pass.
// One item at a time; busy is high while it runs and low again as its last result shows.
// Each result is shown for one cycle on res_valid_o; the receiver cannot stall.
// Reset empties the store and sets max_entries to 16; no clearing pass is needed.
`default_nettype none

module lru_index_watermark_evict_unit
  import lruwe_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               req_i,
  output logic                    res_valid_o,
  output res_t                    res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [4:0] max_entries_q;
  ctl_t       ctl;
  stat_t      st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MAX_ENTRIES) begin
      max_entries_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_MAX_ENTRIES) ? {27'd0, max_entries_q} : 32'd0;

  lruwe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .ctl_o  (ctl)
  );

  lruwe_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .max_entries_i (max_entries_q),
    .ctl_i         (ctl),
    .st_o          (st),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lruwe_chk.sv @@
`default_nettype none

module lruwe_chk
  import lruwe_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic res_valid_o,
  input wire res_t res_o
);

  // an accepted transfer keeps the unit busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // results only follow a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> $past(busy))
    else $error("result without work in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.evicted_valid |-> res_o.evicted_key == 64'd0)
    else $error("evicted key set without eviction");

  // only an eviction may be followed by further results, and the unit stays busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.evicted_valid && busy && !res_o.hit)
    else $error("non-final result that is not an eviction");

endmodule

bind lru_index_watermark_evict_unit lruwe_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import lruwe_pkg::*;

  localparam int SLOTS_N    = 32;
  localparam int MAX_BURST  = MAX_RES;
  localparam int KEY_POOL_N = 48;
  localparam int MAX_GAP    = 40;
  localparam int PHASE_ITEMS = 58;

  localparam logic [1:0]         FUNC_UNUSED      = 2'd3;
  localparam logic [PADDR_W-1:0] MAX_ENTRIES_ADDR = PADDR_W'(4 * REG_MAX_ENTRIES);

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  req_t               req_drv = '0;
  logic               res_valid_o;
  res_t               res_mon;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predicted store contents
  bit              slot_held  [SLOTS_N];
  bit [63:0]       slot_tag   [SLOTS_N];
  bit [31:0]       slot_stamp [SLOTS_N];
  int              held_total = 0;
  logic [4:0]      cap_limit  = MAX_ENTRIES_RST;

  res_t            pending_results [$];
  int              errors     = 0;
  int              idle_pct   = 0;
  int              insert_pct = 46;
  bit [31:0]       now_ctr    = 0;
  bit [63:0]       key_pool [KEY_POOL_N];

  lru_index_watermark_evict_unit #(
    .SLOTS(SLOTS_N)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_drv),
    .res_valid_o(res_valid_o),
    .res_o      (res_mon),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic int find_slot(input bit [63:0] k);
    int i;
    int found;
    found = -1;
    for (i = 0; i < SLOTS_N && found < 0; i++)
      if (slot_held[i] && slot_tag[i] == k) found = i;
    return found;
  endfunction

  function automatic void model_cache_op(input req_t r);
    res_t outs [MAX_BURST];
    res_t e;
    int   n;
    int   s;
    int   i;
    int   best;
    int   target;
    bit   hit;
    bit   added;
    n = 0;
    hit = 1'b0;
    added = 1'b0;
    case (r.func)
      FUNC_LOOKUP: begin
        if (!r.no_compile) begin
          s = find_slot(r.key);
          if (s >= 0) begin
            // a vanished artifact takes its entry with it
            if (!r.artifact_present) begin
              slot_held[s] = 1'b0;
              held_total--;
            end else if (r.copy_ok) begin
              slot_stamp[s] = r.now;
              hit = 1'b1;
            end
          end
        end
      end
      FUNC_INSERT: begin
        if (!r.no_compile) begin
          s = find_slot(r.key);
          if (s >= 0) begin
            slot_stamp[s] = r.now;
          end else if (r.copy_ok) begin
            for (i = 0; i < SLOTS_N && s < 0; i++)
              if (!slot_held[i]) s = i;
            if (s >= 0) begin
              slot_held[s]  = 1'b1;
              slot_tag[s]   = r.key;
              slot_stamp[s] = r.now;
              held_total++;
              added = 1'b1;
            end
          end
        end
        if (added && held_total > int'(cap_limit)) begin
          target = (int'(cap_limit) * 4) / 5;
          while (held_total > target && n < MAX_BURST) begin
            best = -1;
            for (i = 0; i < SLOTS_N; i++)
              if (slot_held[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) best = i;
            slot_held[best] = 1'b0;
            held_total--;
            e = '0;
            e.evicted_valid = 1'b1;
            e.evicted_key   = slot_tag[best];
            e.entry_count   = 6'(held_total);
            outs[n] = e;
            n++;
          end
        end
      end
      FUNC_CLEAR: begin
        for (i = 0; i < SLOTS_N; i++) slot_held[i] = 1'b0;
        held_total = 0;
      end
      default: ;
    endcase
    if (n == 0) begin
      e = '0;
      e.hit = hit;
      e.entry_count = 6'(held_total);
      outs[0] = e;
      n = 1;
    end
    e = outs[n-1];
    e.last = 1'b1;
    outs[n-1] = e;
    for (i = 0; i < n; i++) pending_results.push_back(outs[i]);
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: %h", res_mon));
      end else begin
        want = pending_results.pop_front();
        if (res_mon.hit !== want.hit || res_mon.evicted_valid !== want.evicted_valid ||
            res_mon.evicted_key !== want.evicted_key ||
            res_mon.entry_count !== want.entry_count || res_mon.last !== want.last)
          flag_error($sformatf(
            "expected hit %b ev %b key %h count %0d last %b, got hit %b ev %b key %h count %0d last %b",
            want.hit, want.evicted_valid, want.evicted_key, want.entry_count, want.last,
            res_mon.hit, res_mon.evicted_valid, res_mon.evicted_key, res_mon.entry_count,
            res_mon.last));
      end
    end
  end

  task automatic send_req(input req_t r);
    int gap;
    gap = 0;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      gap++;
    end
    req_drv = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    model_cache_op(r);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = MAX_ENTRIES_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) cap_limit = wdata[4:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_config(input logic [4:0] want);
    logic [31:0] rd;
    apb_transfer(1'b0, 32'd0, rd);
    if (rd !== {27'd0, want})
      flag_error($sformatf("max_entries read: expected %0d, got %h", want, rd));
  endtask

  // wait for every pending result and for the block to drop busy
  task automatic settle(input int tail);
    while (pending_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [4:0] v);
    logic [31:0] rd;
    settle(4);
    // upper bits are junk; only the low five are held
    apb_transfer(1'b1, ($urandom & ~32'h1F) | {27'd0, v}, rd);
    check_config(v);
  endtask

  function automatic req_t mk_req(input logic [1:0] f, input logic [63:0] k,
                                  input logic nc, input logic ap, input logic ok,
                                  input logic [31:0] t);
    req_t r;
    r.func = f;
    r.key = k;
    r.no_compile = nc;
    r.artifact_present = ap;
    r.copy_ok = ok;
    r.now = t;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   sel;
    sel = $urandom_range(99);
    if (sel < insert_pct)  r.func = FUNC_INSERT;
    else if (sel < 96)     r.func = FUNC_LOOKUP;
    else if (sel < 98)     r.func = FUNC_CLEAR;
    else                   r.func = FUNC_UNUSED;
    if ($urandom_range(99) < 88) r.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
    else                         r.key = {$urandom, $urandom};
    r.no_compile       = ($urandom_range(99) < 10);
    r.artifact_present = ($urandom_range(99) < 85);
    r.copy_ok          = ($urandom_range(99) < 85);
    sel = $urandom_range(99);
    if (sel < 10) begin
      r.now = $urandom;
    end else if (sel < 14) begin
      r.now = sel[0] ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      // small steps, zero included, so equal timestamps turn up
      now_ctr += $urandom_range(3);
      r.now = now_ctr;
    end
    return r;
  endfunction

  task automatic check_reset_config();
    check_config(MAX_ENTRIES_RST);
  endtask

  task automatic test_basic_paths();
    send_req(mk_req(FUNC_LOOKUP, 64'd0, 1'b0, 1'b1, 1'b1, 32'd5));
    send_req(mk_req(FUNC_INSERT, 64'd0, 1'b0, 1'b1, 1'b1, 32'd0));
    send_req(mk_req(FUNC_INSERT, '1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_req(mk_req(FUNC_LOOKUP, 64'd0, 1'b0, 1'b1, 1'b1, 32'd100));
    send_req(mk_req(FUNC_LOOKUP, 64'd0, 1'b0, 1'b1, 1'b0, 32'd200));
    send_req(mk_req(FUNC_LOOKUP, '1, 1'b1, 1'b1, 1'b1, 32'd300));
    send_req(mk_req(FUNC_LOOKUP, '1, 1'b0, 1'b0, 1'b1, 32'd400));
    send_req(mk_req(FUNC_LOOKUP, '1, 1'b0, 1'b1, 1'b1, 32'd500));
    send_req(mk_req(FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b1, 32'd600));
    send_req(mk_req(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, 32'd700));
    // a held key is refreshed even when the copy fails
    send_req(mk_req(FUNC_INSERT, 64'd0, 1'b0, 1'b0, 1'b0, 32'd800));
    send_req(mk_req(FUNC_UNUSED, 64'd0, 1'b0, 1'b1, 1'b1, 32'd900));
    send_req(mk_req(FUNC_CLEAR, {$urandom, $urandom}, 1'b1, 1'b0, 1'b0, $urandom));
  endtask

  task automatic test_eviction_order();
    set_limit(5'd4);
    send_req(mk_req(FUNC_INSERT, 64'h0000_0000_0000_00A1, 1'b0, 1'b1, 1'b1, 32'd10));
    send_req(mk_req(FUNC_INSERT, 64'h0000_0000_0000_00B2, 1'b0, 1'b1, 1'b1, 32'd10));
    send_req(mk_req(FUNC_INSERT, 64'h0000_0000_0000_00C3, 1'b0, 1'b1, 1'b1, 32'd7));
    send_req(mk_req(FUNC_INSERT, 64'h0000_0000_0000_00D4, 1'b0, 1'b1, 1'b1, 32'd10));
    // fifth entry: oldest goes first, then the lowest slot among equal stamps
    send_req(mk_req(FUNC_INSERT, 64'h0000_0000_0000_00E5, 1'b0, 1'b1, 1'b1, 32'd20));
    send_req(mk_req(FUNC_LOOKUP, 64'h0000_0000_0000_00B2, 1'b0, 1'b1, 1'b1, 32'd21));
  endtask

  task automatic test_zero_limit();
    set_limit(5'd0);
    send_req(mk_req(FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b1, 32'd30));
    send_req(mk_req(FUNC_INSERT, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 1'b1, 32'd31));
  endtask

  task automatic test_random_phases();
    int p;
    logic [4:0] lim;
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 5'd31;
        1:       lim = 5'd1;
        2:       lim = 5'd0;
        3:       lim = 5'd9;
        4:       lim = 5'($urandom_range(2, 30));
        default: lim = MAX_ENTRIES_RST;
      endcase
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 59;
        default: idle_pct = 36;
      endcase
      // fill the store first so the next, low limit has a backlog to evict
      insert_pct = (p == 0) ? 70 : 46;
      set_limit(lim);
      repeat (PHASE_ITEMS) send_req(random_req());
    end
  endtask

  initial begin : main
    int i;
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    for (i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};
    for (i = 0; i < SLOTS_N; i++) slot_held[i] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    check_reset_config();
    test_basic_paths();
    test_eviction_order();
    test_zero_limit();
    test_random_phases();

    settle(2 * (SLOTS_N + 6));
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lruwe_pkg.sv
hw/rtl/lruwe_ram.sv
hw/rtl/lruwe_ctrl.sv
hw/rtl/lruwe_dp.sv
hw/rtl/lru_index_watermark_evict_unit.sv
hw/rtl/lruwe_chk.sv
test/testbench.sv
